/* hdl/fal_pkg.sv */
package fal_pkg;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

  localparam int HandleWidth = 17;
  localparam int BaseWidth   = 16;
  localparam int WordWidth   = 32;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

endpackage

/* hdl/fal_ctrl.sv */
module fal_ctrl
  import fal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/fal_datapath.sv */
module fal_datapath
  import fal_pkg::*;
#(
  parameter int NUM_SLOTS  = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  input  logic                   cfg_wr_en,
  input  logic [BaseWidth-1:0]   cfg_wr_data,
  input  logic [1:0]             req_type,
  input  logic [HandleWidth-1:0] handle,
  input  logic [WordWidth-1:0]   write_data,
  output logic [1:0]             status,
  output logic [HandleWidth-1:0] result_handle,
  output logic [WordWidth-1:0]   read_data,
  output logic                   in_use
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int MW = $clog2(NUM_SLOTS + 1);
  localparam int LW = SW + 2;

  // link entry: {busy, last, next}
  logic [LW-1:0]         link_mem [NUM_SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];

  logic [BaseWidth-1:0]   base;
  logic [SW-1:0]          head;
  logic                   head_valid;
  logic [MW-1:0]          mark;

  logic [1:0]             req_q;
  logic [HandleWidth-1:0] h_q;
  logic [DATA_WIDTH-1:0]  wd_q;
  logic [SW-1:0]          addr_q;
  logic                   bad_q;
  logic [LW-1:0]          link_rd;
  logic [DATA_WIDTH-1:0]  data_rd;

  logic [HandleWidth:0]   diff;
  logic                   bad;
  logic [SW-1:0]          addr;
  logic [63:0]            wd_wide;
  logic [63:0]            rd_wide;

  logic                   untouched;
  logic                   eff_busy;
  logic                   eff_last;
  logic [SW-1:0]          eff_next;

  logic                   link_we;
  logic [LW-1:0]          link_wdata;
  logic                   data_we;
  logic [1:0]             status_next;
  logic [HandleWidth-1:0] rh_next;
  logic [WordWidth-1:0]   rd_next;
  logic                   used_next;
  logic [SW-1:0]          head_next;
  logic                   head_valid_next;
  logic [MW-1:0]          mark_next;

  assign diff    = {1'b0, handle} - {2'b00, base};
  assign bad     = diff[HandleWidth] ||
                   (diff[HandleWidth-1:0] >= HandleWidth'(NUM_SLOTS));
  assign addr    = (req_type == REQ_ALLOC) ? head : diff[SW-1:0];
  assign wd_wide = {32'b0, write_data};
  assign rd_wide = 64'(data_rd);

  // slots below the mark still hold their reset link
  assign untouched = MW'(addr_q) < mark;
  assign eff_busy  = untouched ? 1'b0 : link_rd[LW-1];
  assign eff_last  = untouched ? (addr_q == '0) : link_rd[LW-2];
  assign eff_next  = untouched ? SW'(addr_q - 1'b1) : link_rd[SW-1:0];

  always_comb begin
    link_we         = 1'b0;
    link_wdata      = '0;
    data_we         = 1'b0;
    status_next     = STAT_OK;
    rh_next         = h_q;
    rd_next         = '0;
    used_next       = 1'b0;
    head_next       = head;
    head_valid_next = head_valid;
    mark_next       = mark;
    case (req_q)
      REQ_ALLOC: begin
        if (!head_valid) begin
          status_next = STAT_EMPTY;
        end else begin
          link_we    = 1'b1;
          link_wdata = {1'b1, eff_last, eff_next};
          data_we    = 1'b1;
          rh_next    = HandleWidth'(addr_q) + HandleWidth'(base);
          if (eff_last) begin
            head_valid_next = 1'b0;
          end else begin
            head_next = eff_next;
          end
          if (untouched) mark_next = MW'(addr_q);
        end
      end
      REQ_READ: begin
        if (bad_q) status_next = STAT_RANGE;
        else if (eff_busy) rd_next = rd_wide[WordWidth-1:0];
        else status_next = STAT_NOT_ALLOC;
      end
      REQ_FREE: begin
        if (bad_q) begin
          status_next = STAT_RANGE;
        end else if (eff_busy) begin
          link_we         = 1'b1;
          link_wdata      = {1'b0, !head_valid, head};
          head_next       = addr_q;
          head_valid_next = 1'b1;
        end else begin
          status_next = STAT_NOT_ALLOC;
        end
      end
      default: begin
        if (bad_q) status_next = STAT_RANGE;
        else used_next = eff_busy;
      end
    endcase
    if (req_q == REQ_READ && bad_q) begin
      status_next = STAT_RANGE;
      rd_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_type;
      h_q     <= handle;
      wd_q    <= wd_wide[DATA_WIDTH-1:0];
      addr_q  <= addr;
      bad_q   <= bad;
      link_rd <= link_mem[addr];
      data_rd <= data_mem[addr];
    end
    if (cmd.commit && link_we) link_mem[addr_q] <= link_wdata;
    if (cmd.commit && data_we) data_mem[addr_q] <= wd_q;
    if (cmd.commit) begin
      status        <= status_next;
      result_handle <= rh_next;
      read_data     <= rd_next;
      in_use        <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      head       <= SW'(NUM_SLOTS - 1);
      head_valid <= 1'b1;
      mark       <= MW'(NUM_SLOTS);
    end else begin
      if (cfg_wr_en) base <= cfg_wr_data;
      if (cmd.commit) begin
        head       <= head_next;
        head_valid <= head_valid_next;
        mark       <= mark_next;
      end
    end
  end

endmodule

/* hdl/free_list_slot_allocator.sv */
// Free-list slot allocator.
// Input channel in_valid/in_ready carries one request word: req_type,
// handle and write_data. Output channel out_valid/out_ready returns one
// response word per request: status, result_handle, read_data, in_use.
// Each request has a read step, of the slot's link and data memories,
// and a write step, back to the link, data and free-list head. A new
// request waits until the previous response is loaded into the output
// register, which holds a response while out_ready is low; the block
// still takes one new request and parks it until the response is taken.
// handle_base is written through cfg_wr_en/cfg_wr_data, by the user
// only while idle; the block does not enforce this.
// Reset is synchronous: no slot busy, free list runs from the top slot
// down to slot 0, handle_base is 0. No clearing pass is needed: a fill
// mark makes never-touched slots read as their reset link, so requests
// are taken right after reset. Slot data is undefined until allocated.
module free_list_slot_allocator
  import fal_pkg::*;
#(
  parameter int NUM_SLOTS  = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [BaseWidth-1:0]   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             req_type,
  input  logic [HandleWidth-1:0] handle,
  input  logic [WordWidth-1:0]   write_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [HandleWidth-1:0] result_handle,
  output logic [WordWidth-1:0]   read_data,
  output logic                   in_use
);

  ctrl_cmd_t cmd;

  fal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fal_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_type      (req_type),
    .handle        (handle),
    .write_data    (write_data),
    .status        (status),
    .result_handle (result_handle),
    .read_data     (read_data),
    .in_use        (in_use)
  );

endmodule

/* hdl/fal_checker.sv */
module fal_checker
  import fal_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             status,
  input logic [HandleWidth-1:0] result_handle,
  input logic [WordWidth-1:0]   read_data,
  input logic                   in_use
);

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(result_handle) && $stable(read_data) && $stable(in_use))
    else $error("stalled response changed");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> !in_use && read_data == '0)
    else $error("error response carries data");

  a_used_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_use |-> status == STAT_OK && read_data == '0)
    else $error("in_use set on a non-query response");

endmodule

bind free_list_slot_allocator fal_checker u_fal_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .result_handle (result_handle),
  .read_data     (read_data),
  .in_use        (in_use)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import fal_pkg::*;

  localparam int NSLOTS = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 306;
  localparam int NUM_PHASES = 5;
  localparam int DIRECTED_ROWS = 21;

  typedef struct packed {
    logic [1:0]             status;
    logic [HandleWidth-1:0] rhandle;
    logic [WordWidth-1:0]   rdata;
    logic                   used;
  } resp_t;

  typedef struct packed {
    logic [1:0]             req;
    logic [HandleWidth-1:0] hnd;
    logic [WordWidth-1:0]   wdata;
    logic                   fixed;
    resp_t                  want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [BaseWidth-1:0]   cfg_wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             req_type;
  logic [HandleWidth-1:0] handle;
  logic [WordWidth-1:0]   write_data;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             status;
  logic [HandleWidth-1:0] result_handle;
  logic [WordWidth-1:0]   read_data;
  logic                   in_use;

  logic                   row_fixed;
  resp_t                  row_fixed_resp;

  // allocator state as the testbench sees it
  logic                   busy_mark [NSLOTS];
  logic [7:0]             next_free [NSLOTS];
  logic                   list_tail [NSLOTS];
  logic [WordWidth-1:0]   slot_word [NSLOTS];
  logic [7:0]             free_top;
  logic                   free_top_ok;
  logic [BaseWidth-1:0]   handle_ofs;

  resp_t pending_resp [$];
  int    errors = 0;
  int    words_in = 0;
  int    words_checked = 0;
  int    seen_empty = 0;
  int    seen_range = 0;
  int    seen_not_alloc = 0;
  int    idle_cycles = 0;
  int    stall_left = 0;
  logic  calm;

  free_list_slot_allocator #(
    .NUM_SLOTS (NSLOTS),
    .DATA_WIDTH(WordWidth)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .handle       (handle),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_handle(result_handle),
    .read_data    (read_data),
    .in_use       (in_use)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_pool();
    for (int s = 0; s < NSLOTS; s++) begin
      busy_mark[s] = 1'b0;
      next_free[s] = (s == 0) ? 8'd0 : 8'(s - 1);
      list_tail[s] = (s == 0);
      slot_word[s] = '0;
    end
    free_top = 8'(NSLOTS - 1);
    free_top_ok = 1'b1;
    handle_ofs = '0;
  endfunction

  function automatic resp_t serve_request(logic [1:0] rt, logic [HandleWidth-1:0] h,
                                          logic [WordWidth-1:0] wd);
    resp_t r;
    int idx;
    int s;
    r.status = STAT_OK;
    r.rhandle = h;
    r.rdata = '0;
    r.used = 1'b0;
    idx = int'(h) - int'(handle_ofs);
    if (rt == REQ_ALLOC) begin
      if (!free_top_ok) begin
        r.status = STAT_EMPTY;
      end else begin
        s = int'(free_top);
        if (list_tail[s]) free_top_ok = 1'b0;
        else free_top = next_free[s];
        busy_mark[s] = 1'b1;
        slot_word[s] = wd;
        r.rhandle = HandleWidth'(s + int'(handle_ofs));
      end
    end else if (idx < 0 || idx >= NSLOTS) begin
      r.status = STAT_RANGE;
    end else if (rt == REQ_READ) begin
      if (busy_mark[idx]) r.rdata = slot_word[idx];
      else r.status = STAT_NOT_ALLOC;
    end else if (rt == REQ_FREE) begin
      if (busy_mark[idx]) begin
        busy_mark[idx] = 1'b0;
        next_free[idx] = free_top;
        list_tail[idx] = !free_top_ok;
        free_top = 8'(idx);
        free_top_ok = 1'b1;
      end else begin
        r.status = STAT_NOT_ALLOC;
      end
    end else begin
      r.used = busy_mark[idx];
    end
    return r;
  endfunction

  function automatic row_t mk_row(logic [1:0] rt, logic [HandleWidth-1:0] h,
                                  logic [WordWidth-1:0] wd, logic fixed, logic [1:0] st,
                                  logic [HandleWidth-1:0] rh, logic [WordWidth-1:0] rd,
                                  logic used);
    row_t w;
    w.req = rt;
    w.hnd = h;
    w.wdata = wd;
    w.fixed = fixed;
    w.want.status = st;
    w.want.rhandle = rh;
    w.want.rdata = rd;
    w.want.used = used;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [HandleWidth-1:0] pick_handle();
    int r;
    int start;
    int s;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      start = $urandom_range(0, NSLOTS - 1);
      s = start;
      for (int k = 0; k < NSLOTS; k++) begin
        s = (start + k) % NSLOTS;
        if (busy_mark[s]) break;
      end
      return HandleWidth'(s + int'(handle_ofs));
    end
    if (r < 85) return HandleWidth'($urandom_range(0, NSLOTS - 1) + int'(handle_ofs));
    if (r < 92) return HandleWidth'(int'(handle_ofs) + NSLOTS + $urandom_range(0, 50));
    if (r < 97 && handle_ofs != 0) return HandleWidth'($urandom_range(0, int'(handle_ofs) - 1));
    return HandleWidth'($urandom);
  endfunction

  function automatic row_t random_word(int alloc_pct);
    row_t w;
    w = '0;
    w.wdata = $urandom;
    if ($urandom_range(0, 99) < alloc_pct) begin
      w.req = REQ_ALLOC;
      w.hnd = HandleWidth'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: w.req = REQ_READ;
        1: w.req = REQ_FREE;
        default: w.req = REQ_QUERY;
      endcase
      w.hnd = pick_handle();
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 50)
      $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(row_t w);
    int gap;
    req_type <= w.req;
    handle <= w.hnd;
    write_data <= w.wdata;
    row_fixed <= w.fixed;
    row_fixed_resp <= w.want;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_base(logic [BaseWidth-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    handle_ofs = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (!rst && out_valid && out_ready) begin
      got.status = status;
      got.rhandle = result_handle;
      got.rdata = read_data;
      got.used = in_use;
      if (pending_resp.size() == 0) begin
        report_mismatch("response word with none pending, handle", 32'(result_handle), 0);
      end else begin
        want = pending_resp.pop_front();
        words_checked++;
        if (want.status == STAT_EMPTY) seen_empty++;
        if (want.status == STAT_RANGE) seen_range++;
        if (want.status == STAT_NOT_ALLOC) seen_not_alloc++;
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.rhandle !== want.rhandle)
          report_mismatch("result_handle", 32'(got.rhandle), 32'(want.rhandle));
        if (got.rdata !== want.rdata)
          report_mismatch("read_data", got.rdata, want.rdata);
        if (got.used !== want.used)
          report_mismatch("in_use", 32'(got.used), 32'(want.used));
      end
    end
    if (!rst && in_valid && in_ready) begin
      want = serve_request(req_type, handle, write_data);
      if (row_fixed) want = row_fixed_resp;
      pending_resp.push_back(want);
      words_in++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d responses pending", idle_cycles,
               pending_resp.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t plan [DIRECTED_ROWS];
    logic [BaseWidth-1:0] bases [NUM_PHASES];
    int sent;
    int chunk;
    int pct;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    req_type = REQ_ALLOC;
    handle = '0;
    write_data = '0;
    row_fixed = 1'b0;
    row_fixed_resp = '0;
    calm = 1'b0;
    clear_pool();

    plan[0]  = mk_row(REQ_QUERY, 17'd255, 0, 1, STAT_OK, 17'd255, 0, 0);
    plan[1]  = mk_row(REQ_READ, 17'd0, 0, 1, STAT_NOT_ALLOC, 17'd0, 0, 0);
    plan[2]  = mk_row(REQ_FREE, 17'd255, 0, 1, STAT_NOT_ALLOC, 17'd255, 0, 0);
    plan[3]  = mk_row(REQ_ALLOC, 17'd0, 32'hFFFF_FFFF, 1, STAT_OK, 17'd255, 0, 0);
    plan[4]  = mk_row(REQ_ALLOC, 17'h1FFFF, 32'h0, 1, STAT_OK, 17'd254, 0, 0);
    plan[5]  = mk_row(REQ_READ, 17'd255, 0, 1, STAT_OK, 17'd255, 32'hFFFF_FFFF, 0);
    plan[6]  = mk_row(REQ_READ, 17'd254, 32'hDEAD_BEEF, 1, STAT_OK, 17'd254, 0, 0);
    plan[7]  = mk_row(REQ_QUERY, 17'd255, 0, 1, STAT_OK, 17'd255, 0, 1);
    plan[8]  = mk_row(REQ_QUERY, 17'd256, 0, 1, STAT_RANGE, 17'd256, 0, 0);
    plan[9]  = mk_row(REQ_READ, 17'h1FFFF, 0, 1, STAT_RANGE, 17'h1FFFF, 0, 0);
    plan[10] = mk_row(REQ_FREE, 17'h1FFFF, 0, 1, STAT_RANGE, 17'h1FFFF, 0, 0);
    plan[11] = mk_row(REQ_FREE, 17'd255, 0, 1, STAT_OK, 17'd255, 0, 0);
    plan[12] = mk_row(REQ_FREE, 17'd255, 0, 1, STAT_NOT_ALLOC, 17'd255, 0, 0);
    plan[13] = mk_row(REQ_QUERY, 17'd255, 0, 1, STAT_OK, 17'd255, 0, 0);
    plan[14] = mk_row(REQ_ALLOC, 17'd7, 32'h1234_5678, 1, STAT_OK, 17'd255, 0, 0);
    plan[15] = mk_row(REQ_ALLOC, 17'h1FFFF, 32'hA5A5_A5A5, 1, STAT_OK, 17'd253, 0, 0);
    plan[16] = mk_row(REQ_READ, 17'd253, 0, 0, STAT_OK, 0, 0, 0);
    plan[17] = mk_row(REQ_FREE, 17'd254, 0, 0, STAT_OK, 0, 0, 0);
    plan[18] = mk_row(REQ_ALLOC, 17'h0AAAA, 32'h5A5A_5A5A, 0, STAT_OK, 0, 0, 0);
    plan[19] = mk_row(REQ_READ, 17'd0, 0, 1, STAT_NOT_ALLOC, 17'd0, 0, 0);
    plan[20] = mk_row(REQ_QUERY, 17'd0, 0, 0, STAT_OK, 0, 0, 0);

    bases[0] = 16'hFFFF;
    bases[1] = 16'h0000;
    bases[2] = BaseWidth'($urandom);
    bases[3] = 16'h0001;
    bases[4] = BaseWidth'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_word(plan[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_base(bases[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // drain the whole pool once, then mix
        if (p == 1 && sent == 0) begin
          chunk = 280;
          pct = 100;
        end else begin
          chunk = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: pct = 15;
            1: pct = 40;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < chunk && sent < PHASE_ITEMS; k++) begin
          send_word(random_word(pct));
          sent++;
        end
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests sent and %0d responses checked across %0d handle bases",
             words_in, words_checked, NUM_PHASES + 1);
    $display("pool empty %0d, out of range %0d, not allocated %0d, mismatches %0d",
             seen_empty, seen_range, seen_not_alloc, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fal_pkg.sv
hdl/fal_ctrl.sv
hdl/fal_datapath.sv
hdl/free_list_slot_allocator.sv
hdl/fal_checker.sv
sim/testbench.sv
